>>> rtl/core/rmkt_pkg.sv
// ============================================================================
// rmkt_pkg - memory key table shared definitions
// Types, widths and codes used by the key table controller, datapath and top.
// ============================================================================
`default_nettype none

package rmkt_pkg;

    // Field widths of the request and response transactions
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 10;
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 31;
    localparam int LEN_W     = 32;
    localparam int STATUS_W  = 2;

    // Width that holds any key or key count up to the largest table (65536)
    localparam int KEY_WIDE_W = 17;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Request operations
    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_UNREGISTER = 2'd1,
        FUNC_VALIDATE   = 2'd2
    } func_t;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_SUB,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic mem_read;  // read the table at the captured key
        logic add_step;  // region end and lower bound check
        logic sub_step;  // room left above the access address
        logic finish;    // update the table and load the response
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_validate;  // captured request is a validate
        logic out_free;     // response register can take a new transaction
    } ctrl_sts_t;

endpackage : rmkt_pkg

`default_nettype wire

>>> rtl/core/rmkt_ctrl.sv
// ============================================================================
// rmkt_ctrl - memory key table controller
// Sequences one request through table read, bound check and response load.
// ============================================================================
`default_nettype none

module rmkt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rmkt_pkg::ctrl_sts_t sts,
    output rmkt_pkg::ctrl_cmd_t      cmd
);
    import rmkt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = sts.op_validate ? ST_ADD : ST_FINISH;
            end
            ST_ADD:
            begin
                cmd.add_step = 1'b1;
                state_next   = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub_step = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here until the response register is free
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Assertions
    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("response loaded while response register occupied");

    a_capture_leads_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_READ))
        else $error("accepted transaction did not start a table read");

    a_add_then_sub: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_step |=> cmd.sub_step)
        else $error("bound check steps out of order");

endmodule : rmkt_ctrl

`default_nettype wire

>>> rtl/core/rmkt_datapath.sv
// ============================================================================
// rmkt_datapath - memory key table datapath
// Request capture, key table memories, key counter, bound check and the
// response register.
// ============================================================================
`default_nettype none

module rmkt_datapath #(
    parameter int TABLE_DEPTH = rmkt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rmkt_pkg::ctrl_cmd_t            cmd,
    output rmkt_pkg::ctrl_sts_t                 sts,
    input  wire logic [rmkt_pkg::FUNC_W-1:0]    func,
    input  wire logic [rmkt_pkg::KEY_W-1:0]     key_in,
    input  wire logic [rmkt_pkg::ADDR_W-1:0]    region_base,
    input  wire logic [rmkt_pkg::SIZE_W-1:0]    region_size,
    input  wire logic [rmkt_pkg::ADDR_W-1:0]    access_address,
    input  wire logic [rmkt_pkg::LEN_W-1:0]     access_length,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rmkt_pkg::STATUS_W-1:0]       status,
    output logic [rmkt_pkg::KEY_W-1:0]          key_out,
    output logic [rmkt_pkg::ADDR_W-1:0]         granted_address
);
    import rmkt_pkg::*;

    localparam int KW  = $clog2(TABLE_DEPTH);
    localparam int NKW = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDE_W-1:0] DEPTH_WIDE = KEY_WIDE_W'(TABLE_DEPTH);
    localparam logic [NKW-1:0]        DEPTH_NK   = NKW'(TABLE_DEPTH);

    // Captured request
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;

    // Table memories
    logic [ADDR_W-1:0] base_mem  [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_mem  [TABLE_DEPTH];
    logic              valid_mem [TABLE_DEPTH];

    logic [ADDR_W-1:0] base_rd_reg;
    logic [SIZE_W-1:0] size_rd_reg;
    logic              valid_rd_reg;

    // Bound check pipeline registers
    logic [ADDR_W-1:0] end_reg;
    logic              below_base_reg;
    logic              key_ok_reg;
    logic [ADDR_W-1:0] room_reg;
    logic              above_end_reg;

    // Key counter and response register
    logic [NKW-1:0]      next_key_reg;
    logic [NKW-1:0]      next_key_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [KEY_W-1:0]    key_out_reg;
    logic [KEY_W-1:0]    key_out_next;
    logic [ADDR_W-1:0]   granted_reg;
    logic [ADDR_W-1:0]   granted_next;

    logic [KEY_WIDE_W-1:0] key_wide;
    logic [KEY_WIDE_W-1:0] next_key_wide;
    logic [KW-1:0]         key_idx;
    logic [KW-1:0]         new_idx;
    logic                  key_in_range;
    logic                  table_full;
    logic                  len_too_long;
    logic                  check_fail;
    logic                  reg_we;
    logic                  unreg_we;
    logic [ADDR_W:0]       room_full;

    // Key decode
    assign key_wide      = KEY_WIDE_W'(key_reg);
    assign next_key_wide = KEY_WIDE_W'(next_key_reg);
    assign key_idx       = key_wide[KW-1:0];
    assign new_idx       = next_key_wide[KW-1:0];
    assign key_in_range  = (key_wide < DEPTH_WIDE);
    assign table_full    = (next_key_reg == DEPTH_NK);

    // Status to controller
    assign sts.op_validate = (func_reg == FUNC_VALIDATE);
    assign sts.out_free    = !out_valid_reg || out_ready;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            key_reg  <= key_in;
            base_reg <= region_base;
            size_reg <= region_size;
            addr_reg <= access_address;
            len_reg  <= access_length;
        end
    end

    // Table write port: register stores a region, unregister clears its mark
    assign reg_we   = cmd.finish && (func_reg == FUNC_REGISTER) && !table_full;
    assign unreg_we = cmd.finish && (func_reg == FUNC_UNREGISTER) && key_in_range;

    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            base_mem[new_idx]  <= base_reg;
            size_mem[new_idx]  <= size_reg;
            valid_mem[new_idx] <= 1'b1;
        end
        else if (unreg_we)
        begin
            valid_mem[key_idx] <= 1'b0;
        end
    end

    // Table read port; only meaningful for an in-range key
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read && key_in_range)
        begin
            base_rd_reg  <= base_mem[key_idx];
            size_rd_reg  <= size_mem[key_idx];
            valid_rd_reg <= valid_mem[key_idx];
        end
    end

    // Check step one: region end, lower bound, key validity.
    // Keys at or above the counter were never handed out, so their marks
    // are clear regardless of what the valid memory holds.
    always_ff @(posedge clk)
    begin
        if (cmd.add_step)
        begin
            end_reg        <= base_rd_reg + ADDR_W'(size_rd_reg);
            below_base_reg <= (addr_reg < base_rd_reg);
            key_ok_reg     <= key_in_range && (key_wide != '0)
                              && (key_wide < next_key_wide) && valid_rd_reg;
        end
    end

    // Check step two: room between access address and region end
    assign room_full = {1'b0, end_reg} - {1'b0, addr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.sub_step)
        begin
            room_reg      <= room_full[ADDR_W-1:0];
            above_end_reg <= room_full[ADDR_W];
        end
    end

    // Final length compare: length is narrower than the room word
    assign len_too_long = (room_reg[ADDR_W-1:LEN_W] == '0)
                          && (len_reg > room_reg[LEN_W-1:0]);
    assign check_fail   = !key_ok_reg || below_base_reg || above_end_reg
                          || len_too_long;

    // Response and counter update
    always_comb
    begin
        next_key_next  = next_key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        key_out_next   = key_out_reg;
        granted_next   = granted_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_INVALID;
            key_out_next   = '0;
            granted_next   = '0;
            case (func_t'(func_reg))
                FUNC_REGISTER:
                begin
                    if (table_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next   = STATUS_OK;
                        key_out_next  = next_key_wide[KEY_W-1:0];
                        next_key_next = next_key_reg + NKW'(1);
                    end
                end
                FUNC_UNREGISTER:
                begin
                    status_next = STATUS_OK;
                end
                FUNC_VALIDATE:
                begin
                    if (!check_fail)
                    begin
                        status_next  = STATUS_OK;
                        granted_next = addr_reg;
                    end
                end
                default:
                begin
                    status_next = STATUS_INVALID;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_key_reg  <= NKW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            next_key_reg  <= next_key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        key_out_reg <= key_out_next;
        granted_reg <= granted_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign key_out         = key_out_reg;
    assign granted_address = granted_reg;

    // Assertions
    a_key_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_key_reg != '0) && (next_key_reg <= DEPTH_NK))
        else $error("key counter out of range");

    a_key_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (next_key_reg >= $past(next_key_reg)))
        else $error("key counter moved backwards");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK))
        |-> ((key_out_reg == '0) && (granted_reg == '0)))
        else $error("failed transaction carries a key or an address");

endmodule : rmkt_datapath

`default_nettype wire

>>> rtl/core/rdma_memory_key_table.sv
// ============================================================================
// rdma_memory_key_table - memory region key table
// Registers regions under monotonic keys, unregisters them and validates
// accesses against a region's bounds.
// ============================================================================
// One request is handled at a time. A register, unregister or unknown request
// steps through accept, table read and table update before its response; a
// validate steps through accept, table read, region end, room above the
// address and response, since the bound check splits into two 64-bit
// add/subtract steps behind the single table read port. The response sits in
// an output register, so the next request is accepted while a response waits
// to be taken; a stalled response holds the block in its last step. Keys start
// at 1, are never reused and run up to TABLE_DEPTH-1, after which register
// requests answer table full. Valid marks need no clearing pass after reset: a
// key at or above the key counter always reads as invalid.
`default_nettype none

module rdma_memory_key_table #(
    parameter int TABLE_DEPTH = rmkt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rmkt_pkg::FUNC_W-1:0]    func,
    input  wire logic [rmkt_pkg::KEY_W-1:0]     key_in,
    input  wire logic [rmkt_pkg::ADDR_W-1:0]    region_base,
    input  wire logic [rmkt_pkg::SIZE_W-1:0]    region_size,
    input  wire logic [rmkt_pkg::ADDR_W-1:0]    access_address,
    input  wire logic [rmkt_pkg::LEN_W-1:0]     access_length,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rmkt_pkg::STATUS_W-1:0]       status,
    output logic [rmkt_pkg::KEY_W-1:0]          key_out,
    output logic [rmkt_pkg::ADDR_W-1:0]         granted_address
);
    import rmkt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer
    rmkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, bound check and response register
    rmkt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .key_in          (key_in),
        .region_base     (region_base),
        .region_size     (region_size),
        .access_address  (access_address),
        .access_length   (access_length),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .key_out         (key_out),
        .granted_address (granted_address)
    );

endmodule : rdma_memory_key_table

`default_nettype wire
